// ----- hw/rtl/awb_pkg.sv -----
// Shared types and constants for the affine warp bilinear sampler.
// Used by the sample bank RAM and the top level; no dependencies.
`timescale 1ns / 1ps

package awb_pkg;

    // Source store geometry.
    localparam int MAX_SRC_W = 256;
    localparam int MAX_SRC_H = 256;
    localparam int CHANNELS  = 4;
    localparam int XW        = $clog2(MAX_SRC_W);
    localparam int YW        = $clog2(MAX_SRC_H);
    localparam int BANK_AW   = (XW - 1) + (YW - 1);
    localparam int BANK_DEPTH = (MAX_SRC_W / 2) * (MAX_SRC_H / 2);
    localparam int NBANKS    = 4;

    // Input word kinds.
    typedef enum logic [1:0] {
        KIND_LOAD    = 2'd0,
        KIND_BILIN   = 2'd1,
        KIND_NEAREST = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // Configuration register indexes.
    localparam logic [2:0] REG_COEF_XX  = 3'd0;
    localparam logic [2:0] REG_COEF_XY  = 3'd1;
    localparam logic [2:0] REG_SHIFT_X  = 3'd2;
    localparam logic [2:0] REG_COEF_YX  = 3'd3;
    localparam logic [2:0] REG_COEF_YY  = 3'd4;
    localparam logic [2:0] REG_SHIFT_Y  = 3'd5;
    localparam logic [2:0] REG_SRC_W    = 3'd6;
    localparam logic [2:0] REG_SRC_H    = 3'd7;

    // Write request into one bank of the source store.
    typedef struct packed {
        logic               we;
        logic [BANK_AW-1:0] addr;
        logic [31:0]        data;
    } awb_wr_t;

endpackage

// ----- hw/rtl/awb_bank.sv -----
// One parity bank of the source image store: one write and one registered read port.
// Depends on awb_pkg for geometry and the write request struct.
`timescale 1ns / 1ps

module awb_bank (
    input  logic                       clk,
    input  awb_pkg::awb_wr_t           wr,
    input  logic                       rd_en,
    input  logic [awb_pkg::BANK_AW-1:0] rd_addr,
    output logic [31:0]                rd_data
);
    import awb_pkg::*;

    logic [31:0] mem [BANK_DEPTH];
    logic [31:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    // Registered read port; holds while the pipeline is stalled.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hw/rtl/affine_warp_bilinear_sampler_unit.sv -----
// Affine warp sampler: inverse affine mapping in Q15.16 and bilinear/nearest fetch.
// The pipeline takes one word per cycle unless a waiting result is held by out_stall.
// Four parity banks of the source store let the four neighbors be read together in the same cycle.
// The whole pipeline advances together; it holds only while a result waits stalled.
// Reset (rst_n low, asynchronous) clears valid bits and sets the identity transform
// and a 256 x 256 source; the source image is undefined until loaded.
`timescale 1ns / 1ps

module affine_warp_bilinear_sampler_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port.
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    // Input channel.
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [9:0]  coord_x,
    input  logic [9:0]  coord_y,
    input  logic [31:0] load_pixel,
    // Output channel.
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] out_pixel,
    output logic        inside_res
);
    import awb_pkg::*;

    // Configuration registers.
    logic signed [31:0] coef_xx_reg, coef_xy_reg, shift_x_reg;
    logic signed [31:0] coef_yx_reg, coef_yy_reg, shift_y_reg;
    logic [8:0]         src_w_reg, src_h_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_xx_reg <= 32'sd65536;
            coef_xy_reg <= '0;
            shift_x_reg <= '0;
            coef_yx_reg <= '0;
            coef_yy_reg <= 32'sd65536;
            shift_y_reg <= '0;
            src_w_reg   <= 9'd256;
            src_h_reg   <= 9'd256;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_COEF_XX: coef_xx_reg <= cfg_data;
                REG_COEF_XY: coef_xy_reg <= cfg_data;
                REG_SHIFT_X: shift_x_reg <= cfg_data;
                REG_COEF_YX: coef_yx_reg <= cfg_data;
                REG_COEF_YY: coef_yy_reg <= cfg_data;
                REG_SHIFT_Y: shift_y_reg <= cfg_data;
                REG_SRC_W:   src_w_reg   <= cfg_data[8:0];
                REG_SRC_H:   src_h_reg   <= cfg_data[8:0];
                default:     ;
            endcase
        end
    end

    // Border limits: (min(dim, max) - 1) << 16, signed so a zero size admits nothing.
    logic [8:0]         w_sat, h_sat;
    logic signed [9:0]  wm1, hm1;
    logic signed [44:0] lim_x, lim_y;

    always_comb
    begin
        w_sat = (src_w_reg > 9'(MAX_SRC_W)) ? 9'(MAX_SRC_W) : src_w_reg;
        h_sat = (src_h_reg > 9'(MAX_SRC_H)) ? 9'(MAX_SRC_H) : src_h_reg;
        wm1   = $signed({1'b0, w_sat}) - 10'sd1;
        hm1   = $signed({1'b0, h_sat}) - 10'sd1;
        lim_x = 45'(wm1) <<< 16;
        lim_y = 45'(hm1) <<< 16;
    end

    // Global advance: the pipeline moves unless a result waits stalled.
    logic en;
    logic out_valid_reg;

    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    // Stage 1: input register.
    logic        v1_reg;
    kind_t       k1_reg;
    logic [9:0]  cx1_reg, cy1_reg;
    logic [31:0] lp1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k1_reg  <= kind_t'(kind);
            cx1_reg <= coord_x;
            cy1_reg <= coord_y;
            lp1_reg <= load_pixel;
        end
    end

    // Stage 2: the four matrix products.
    logic               v2_reg;
    kind_t              k2_reg;
    logic [9:0]         cx2_reg, cy2_reg;
    logic [31:0]        lp2_reg;
    logic signed [42:0] pxx2_reg, pxy2_reg, pyx2_reg, pyy2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k2_reg   <= k1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            lp2_reg  <= lp1_reg;
            pxx2_reg <= coef_xx_reg * $signed({1'b0, cx1_reg});
            pxy2_reg <= coef_xy_reg * $signed({1'b0, cy1_reg});
            pyx2_reg <= coef_yx_reg * $signed({1'b0, cx1_reg});
            pyy2_reg <= coef_yy_reg * $signed({1'b0, cy1_reg});
        end
    end

    // Stage 3: source point sums.
    logic               v3_reg;
    kind_t              k3_reg;
    logic [9:0]         cx3_reg, cy3_reg;
    logic [31:0]        lp3_reg;
    logic signed [44:0] sx3_reg, sy3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k3_reg  <= k2_reg;
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
            lp3_reg <= lp2_reg;
            sx3_reg <= 45'(pxx2_reg) + 45'(pxy2_reg) + 45'(shift_x_reg);
            sy3_reg <= 45'(pyx2_reg) + 45'(pyy2_reg) + 45'(shift_y_reg);
        end
    end

    // Stage 4: border test, base pixel and fractions.
    // Nearest mode becomes a bilinear fetch at the rounded point with zero fractions.
    logic               v4_reg;
    kind_t              k4_reg;
    logic [9:0]         cx4_reg, cy4_reg;
    logic [31:0]        lp4_reg;
    logic               in4_reg;
    logic [XW-1:0]      xa4_reg;
    logic [YW-1:0]      ya4_reg;
    logic [15:0]        fx4_reg, fy4_reg;
    logic signed [44:0] sxr, syr;
    logic               inside3;

    always_comb
    begin
        sxr     = sx3_reg + 45'sd32768;
        syr     = sy3_reg + 45'sd32768;
        inside3 = (sx3_reg > 45'sd0) && (sy3_reg > 45'sd0) &&
                  (sx3_reg < lim_x) && (sy3_reg < lim_y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k4_reg  <= k3_reg;
            cx4_reg <= cx3_reg;
            cy4_reg <= cy3_reg;
            lp4_reg <= lp3_reg;
            in4_reg <= inside3;
            if (k3_reg == KIND_NEAREST)
            begin
                xa4_reg <= sxr[16 +: XW];
                ya4_reg <= syr[16 +: YW];
                fx4_reg <= '0;
                fy4_reg <= '0;
            end
            else
            begin
                xa4_reg <= sx3_reg[16 +: XW];
                ya4_reg <= sy3_reg[16 +: YW];
                fx4_reg <= sx3_reg[15:0];
                fy4_reg <= sy3_reg[15:0];
            end
        end
    end

    // Bank access: loads write their parity bank; samples read all four neighbors.
    logic [XW-1:0]      xp1;
    logic [YW-1:0]      yp1;
    logic               load_ok;
    awb_wr_t            bank_wr   [NBANKS];
    logic [BANK_AW-1:0] bank_addr [NBANKS];
    logic [31:0]        bank_q    [NBANKS];

    always_comb
    begin
        xp1     = xa4_reg + XW'(1);
        yp1     = ya4_reg + YW'(1);
        load_ok = en && v4_reg && (k4_reg == KIND_LOAD) &&
                  (cx4_reg < 10'(MAX_SRC_W)) && (cy4_reg < 10'(MAX_SRC_H));
    end

    for (genvar b = 0; b < NBANKS; b++)
    begin : g_bank
        logic [XW-2:0] col;
        logic [YW-2:0] row;

        always_comb
        begin
            col = (xa4_reg[0] == b[0]) ? xa4_reg[XW-1:1] : xp1[XW-1:1];
            row = (ya4_reg[0] == b[1]) ? ya4_reg[YW-1:1] : yp1[YW-1:1];
            bank_addr[b]    = {row, col};
            bank_wr[b].we   = load_ok && (cx4_reg[0] == b[0]) && (cy4_reg[0] == b[1]);
            bank_wr[b].addr = {cy4_reg[YW-1:1], cx4_reg[XW-1:1]};
            bank_wr[b].data = lp4_reg;
        end

        awb_bank u_bank (
            .clk     (clk),
            .wr      (bank_wr[b]),
            .rd_en   (en),
            .rd_addr (bank_addr[b]),
            .rd_data (bank_q[b])
        );
    end

    // Stage 5: control that travels beside the bank read data.
    logic        v5_reg, res5_reg, in5_reg;
    logic        xo5_reg, yo5_reg;
    logic [15:0] fx5_reg, fy5_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v5_reg   <= 1'b0;
            res5_reg <= 1'b0;
        end
        else if (en)
        begin
            v5_reg   <= v4_reg;
            res5_reg <= v4_reg && (k4_reg == KIND_BILIN || k4_reg == KIND_NEAREST);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in5_reg <= in4_reg;
            xo5_reg <= xa4_reg[0];
            yo5_reg <= ya4_reg[0];
            fx5_reg <= fx4_reg;
            fy5_reg <= fy4_reg;
        end
    end

    // Neighbor selection; a zero fraction points the far neighbor back at the base.
    logic        fxnz, fynz;
    logic [31:0] p00, p10, p01, p11;

    always_comb
    begin
        fxnz = (fx5_reg != 16'd0);
        fynz = (fy5_reg != 16'd0);
        p00  = bank_q[{yo5_reg, xo5_reg}];
        p10  = bank_q[{yo5_reg, xo5_reg ^ fxnz}];
        p01  = bank_q[{yo5_reg ^ fynz, xo5_reg}];
        p11  = bank_q[{yo5_reg ^ fynz, xo5_reg ^ fxnz}];
    end

    // Stage 6: per channel differences and fraction products.
    logic               v6_reg, res6_reg, in6_reg;
    logic [31:0]        fxy6_reg;
    logic signed [25:0] afx6_reg [CHANNELS];
    logic signed [25:0] bfy6_reg [CHANNELS];
    logic signed [10:0] c6_reg   [CHANNELS];
    logic [7:0]         d6_reg   [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v6_reg   <= 1'b0;
            res6_reg <= 1'b0;
        end
        else if (en)
        begin
            v6_reg   <= v5_reg;
            res6_reg <= res5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in6_reg  <= in5_reg;
            fxy6_reg <= fx5_reg * fy5_reg;
        end
    end

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_diff
        logic signed [8:0]  dv, av, bv;
        logic signed [10:0] cv;

        always_comb
        begin
            dv = $signed({1'b0, p00[8*ch +: 8]});
            av = $signed({1'b0, p10[8*ch +: 8]}) - dv;
            bv = $signed({1'b0, p01[8*ch +: 8]}) - dv;
            cv = $signed({3'b000, p11[8*ch +: 8]}) - 11'(av) - 11'(bv) - 11'(dv);
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                afx6_reg[ch] <= av * $signed({1'b0, fx5_reg});
                bfy6_reg[ch] <= bv * $signed({1'b0, fy5_reg});
                c6_reg[ch]   <= cv;
                d6_reg[ch]   <= p00[8*ch +: 8];
            end
        end
    end

    // Stage 7: cross term.
    logic               v7_reg, res7_reg, in7_reg;
    logic signed [43:0] cf7_reg  [CHANNELS];
    logic signed [25:0] afx7_reg [CHANNELS];
    logic signed [25:0] bfy7_reg [CHANNELS];
    logic [7:0]         d7_reg   [CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v7_reg   <= 1'b0;
            res7_reg <= 1'b0;
        end
        else if (en)
        begin
            v7_reg   <= v6_reg;
            res7_reg <= res6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in7_reg <= in6_reg;
        end
    end

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_cross
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cf7_reg[ch]  <= c6_reg[ch] * $signed({1'b0, fxy6_reg});
                afx7_reg[ch] <= afx6_reg[ch];
                bfy7_reg[ch] <= bfy6_reg[ch];
                d7_reg[ch]   <= d6_reg[ch];
            end
        end
    end

    // Accumulate, truncate and clamp each channel; unused channels and outside points are zero.
    logic [31:0] pix7;

    for (genvar ch = 0; ch < 4; ch++)
    begin : g_acc
        logic signed [46:0] acc;
        logic [7:0]         val;

        if (ch < CHANNELS)
        begin : g_used
            always_comb
            begin
                acc = (47'(afx7_reg[ch]) <<< 16) + (47'(bfy7_reg[ch]) <<< 16) +
                      47'(cf7_reg[ch]) + $signed({7'd0, d7_reg[ch], 32'd0});
                if (acc < 47'sd0)
                begin
                    val = 8'd0;
                end
                else if (acc[45:32] > 14'd255)
                begin
                    val = 8'd255;
                end
                else
                begin
                    val = acc[39:32];
                end
                pix7[8*ch +: 8] = in7_reg ? val : 8'd0;
            end
        end
        else
        begin : g_unused
            always_comb
            begin
                acc = '0;
                val = '0;
                pix7[8*ch +: 8] = val | acc[7:0];
            end
        end
    end

    // Stage 8: output register.
    logic [31:0] out_pixel_reg;
    logic        inside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v7_reg && res7_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_pixel_reg <= pix7;
            inside_reg    <= in7_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_pixel  = out_pixel_reg;
    assign inside_res = inside_reg;

`ifndef ASSERT_OFF
    // A point outside the source always yields an all-zero word.
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !inside_res |-> out_pixel == 32'd0)
        else $error("outside sample gave a nonzero pixel");

    // A load writes at most one parity bank.
    a_one_bank: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({bank_wr[3].we, bank_wr[2].we, bank_wr[1].we, bank_wr[0].we}))
        else $error("load wrote more than one bank");

    // Nothing is written while the pipeline holds.
    a_no_write_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !en |-> !(bank_wr[0].we || bank_wr[1].we || bank_wr[2].we || bank_wr[3].we))
        else $error("bank written during a stall");

    // A result needs a valid word in the stage before the output.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(v7_reg && res7_reg))
        else $error("result word without a sample behind it");
`endif

endmodule
